[src/key_action_debouncer_unit_macros.svh]
// ----------------------------------------------------------------------------
// Key action debouncer assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_ACTION_DEBOUNCER_UNIT_MACROS_SVH
`define KEY_ACTION_DEBOUNCER_UNIT_MACROS_SVH

`ifndef SYNTH
`define KAD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define KAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define KAD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define KAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[src/kad_pkg.sv]
// ----------------------------------------------------------------------------
// Key action debouncer package
// Shared types, register codes, constants and a timer helper.
// ----------------------------------------------------------------------------
package kad_pkg;

    localparam int KEY_COUNT = 8;

    localparam logic [1:0] ACT_IDLE     = 2'd0;
    localparam logic [1:0] ACT_PRESSED  = 2'd1;
    localparam logic [1:0] ACT_RELEASED = 2'd2;

    localparam logic [1:0] CFG_TICK_PERIOD   = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE_TIME = 2'd1;
    localparam logic [1:0] CFG_NOTIFY_ENABLE = 2'd2;
    localparam logic [1:0] CFG_CLICK_GAP     = 2'd3;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;
    localparam logic [7:0]  CLICK_MAX = 8'hFF;

    localparam logic [15:0] RST_TICK_PERIOD   = 16'd10;
    localparam logic [15:0] RST_DEBOUNCE_TIME = 16'd20;
    localparam logic [7:0]  RST_NOTIFY_ENABLE = 8'd0;
    localparam logic [15:0] RST_CLICK_GAP     = 16'd300;

    typedef struct packed {
        logic [2:0] key_index;
        logic       key_level;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  key_number;
        logic [1:0]  action;
        logic        notify_changed;
        logic        notify_timed;
        logic [15:0] press_time;
        logic [15:0] release_time;
        logic [7:0]  click_count;
    } t_out_item;

    typedef struct packed {
        logic [15:0] tick_period;
        logic [15:0] debounce_time;
        logic [7:0]  notify_enable;
        logic [15:0] click_gap;
    } t_cfg;

    // Timer advances by tp only while it is below TIMER_MAX minus tp.
    function automatic logic [15:0] sat_add(input logic [15:0] t, input logic [15:0] tp);
        logic [16:0] limit;
        logic [16:0] sum;
        limit = {1'b0, TIMER_MAX} - {1'b0, tp};
        sum   = {1'b0, t} + {1'b0, tp};
        if ({1'b0, t} < limit) begin
            return sum[15:0];
        end
        return t;
    endfunction

endpackage

[src/key_action_debouncer_unit.sv]
// Throughput: one transaction per cycle unless the output stalls; the per-key
// record is read and written back in the same cycle, so the next tick of the
// same key sees the updated state.
// Reset (synchronous, active low) clears all key records, empties both pipeline
// registers and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// Key action debouncer top level
// Input register, single-pass key state update and output register.
// ----------------------------------------------------------------------------
`include "key_action_debouncer_unit_macros.svh"

module key_action_debouncer_unit import kad_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_advance;
    logic      w_accept;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    kad_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    kad_key_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_advance & r_in_valid),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept || (r_in_valid && !w_advance);
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (w_advance && r_in_valid) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `KAD_ASSERT_IMPLY(a_stall_needs_item, i_clk, i_rst_n, o_in_stall, r_in_valid)
    `KAD_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)
    `KAD_ASSERT_IMPLY(a_click_when_idle, i_clk, i_rst_n,
        r_out_valid && (r_out.click_count != '0), r_out.action == ACT_IDLE)

endmodule

[src/kad_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Key action debouncer configuration registers
// Holds tick period, debounce time, notify enables and click gap.
// ----------------------------------------------------------------------------
module kad_cfg_regs import kad_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_period   <= RST_TICK_PERIOD;
            r_cfg.debounce_time <= RST_DEBOUNCE_TIME;
            r_cfg.notify_enable <= RST_NOTIFY_ENABLE;
            r_cfg.click_gap     <= RST_CLICK_GAP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TICK_PERIOD:   r_cfg.tick_period   <= i_cfg_data;
                CFG_DEBOUNCE_TIME: r_cfg.debounce_time <= i_cfg_data;
                CFG_NOTIFY_ENABLE: r_cfg.notify_enable <= i_cfg_data[7:0];
                CFG_CLICK_GAP:     r_cfg.click_gap     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/kad_key_state.sv]
// ----------------------------------------------------------------------------
// Key action debouncer per-key state
// Per-key records and the single-pass update of one scan tick.
// ----------------------------------------------------------------------------
module kad_key_state import kad_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_update,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [1:0]  r_action  [KEY_COUNT];
    logic [1:0]  r_prev    [KEY_COUNT];
    logic [15:0] r_pressed [KEY_COUNT];
    logic [15:0] r_released[KEY_COUNT];
    logic [15:0] r_count   [KEY_COUNT];
    logic [7:0]  r_clicks  [KEY_COUNT];

    logic [2:0]  w_idx;
    logic        w_key_ok;
    logic        w_enabled;
    logic [1:0]  w_act;
    logic [1:0]  w_prev;
    logic [15:0] w_pr;
    logic [15:0] w_rl;
    logic [15:0] w_cd;
    logic [7:0]  w_ck;
    logic [1:0]  n_act;
    logic [15:0] n_pr;
    logic [15:0] n_rl;
    logic [15:0] n_cd;
    logic [7:0]  n_ck;
    logic        w_changed;
    logic        w_timed;
    logic [7:0]  w_done;

    assign w_idx     = i_item.key_index;
    assign w_key_ok  = (32'(w_idx) < KEY_COUNT);
    assign w_enabled = i_cfg.notify_enable[w_idx];
    assign w_act     = r_action[w_idx];
    assign w_prev    = r_prev[w_idx];
    assign w_pr      = r_pressed[w_idx];
    assign w_rl      = r_released[w_idx];
    assign w_cd      = r_count[w_idx];
    assign w_ck      = r_clicks[w_idx];

    always_comb begin
        n_act     = w_act;
        n_pr      = w_pr;
        n_rl      = w_rl;
        n_cd      = w_cd;
        n_ck      = w_ck;
        w_changed = 1'b0;
        w_timed   = 1'b0;
        w_done    = '0;

        if (!i_item.key_level) begin
            if (w_act == ACT_PRESSED) begin
                n_rl = sat_add(w_rl, i_cfg.tick_period);
                if (n_rl >= i_cfg.debounce_time) begin
                    n_act = ACT_RELEASED;
                end
            end else begin
                n_act = ACT_IDLE;
                n_pr  = '0;
                n_rl  = sat_add(w_rl, i_cfg.tick_period);
            end
        end else begin
            if (w_act != ACT_RELEASED) begin
                if (w_act == ACT_PRESSED) begin
                    n_rl = '0;
                end
                n_pr = sat_add(w_pr, i_cfg.tick_period);
                if (n_pr >= i_cfg.debounce_time) begin
                    n_act = ACT_PRESSED;
                end
            end else begin
                n_act = ACT_IDLE;
                n_pr  = '0;
                n_rl  = 16'd1;
            end
        end

        if (w_enabled) begin
            if (w_cd != '0) begin
                if (w_cd >= i_cfg.tick_period) begin
                    n_cd = w_cd - i_cfg.tick_period;
                end else begin
                    n_cd = '0;
                end
                w_timed = (n_cd == '0);
            end
            w_changed = (n_act != w_prev);
            if (w_timed || w_changed) begin
                if (n_act == ACT_RELEASED) begin
                    n_cd = i_cfg.click_gap;
                end
                if (w_prev != ACT_PRESSED && n_act == ACT_PRESSED) begin
                    n_cd = '0;
                    if (w_ck < CLICK_MAX) begin
                        n_ck = w_ck + 8'd1;
                    end
                end
                if (n_act == ACT_IDLE && n_rl >= i_cfg.click_gap) begin
                    w_done = n_ck;
                    n_ck   = '0;
                end
            end
        end

        o_result.key_number     = w_idx;
        o_result.action         = w_key_ok ? n_act : ACT_IDLE;
        o_result.notify_changed = w_key_ok & w_changed;
        o_result.notify_timed   = w_key_ok & w_timed;
        o_result.press_time     = w_key_ok ? n_pr : '0;
        o_result.release_time   = w_key_ok ? n_rl : '0;
        o_result.click_count    = w_key_ok ? w_done : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_COUNT; i++) begin
                r_action[i]   <= ACT_IDLE;
                r_prev[i]     <= ACT_IDLE;
                r_pressed[i]  <= '0;
                r_released[i] <= '0;
                r_count[i]    <= '0;
                r_clicks[i]   <= '0;
            end
        end else if (i_update && w_key_ok) begin
            r_action[w_idx]   <= n_act;
            r_prev[w_idx]     <= n_act;
            r_pressed[w_idx]  <= n_pr;
            r_released[w_idx] <= n_rl;
            r_count[w_idx]    <= n_cd;
            r_clicks[w_idx]   <= n_ck;
        end
    end

endmodule

[dv/key_action_debouncer_unit_tb.sv]
// ----------------------------------------------------------------------------
// Key action debouncer unit testbench
// Sends scan ticks through the valid/stall input channel and predicts each
// result with a cycle-free model of the per-key debounce, notify and click
// logic. Each result is checked field by field against that prediction. The
// run covers several register settings, both random and extreme, a click burst
// long enough to saturate the click counter, random idling on both channels and
// one long output hold-off.
// ----------------------------------------------------------------------------
module key_action_debouncer_unit_tb;
    import kad_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 80;
    localparam int BURST_CLICKS = 260;
    localparam int PHASE_TICKS  = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    in_item = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    key_action_debouncer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    t_in_item  pending_ticks[$];
    t_out_item expected_reports[$];

    int   idle_pct = 33;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    logic in_taken = 1'b0;

    int queued_total = 0;
    int checked_total = 0;
    int mismatch_total = 0;
    int settings_total = 0;
    int top_burst = 0;

    t_cfg        cfg_model;
    logic [1:0]  key_act      [KEY_COUNT];
    logic [1:0]  last_act     [KEY_COUNT];
    logic [15:0] held_ms      [KEY_COUNT];
    logic [15:0] open_ms      [KEY_COUNT];
    logic [15:0] alert_left   [KEY_COUNT];
    logic [7:0]  burst_clicks [KEY_COUNT];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [15:0] advance_timer(input logic [15:0] t);
        if (int'(t) < int'(TIMER_MAX) - int'(cfg_model.tick_period)) begin
            return t + cfg_model.tick_period;
        end
        return t;
    endfunction

    function automatic t_out_item predict_scan(input t_in_item tick);
        int         k;
        logic       changed;
        logic       timed;
        logic [7:0] done;
        t_out_item  r;
        k = int'(tick.key_index);
        changed = 1'b0;
        timed = 1'b0;
        done = '0;
        if (!tick.key_level) begin
            if (key_act[k] == ACT_PRESSED) begin
                open_ms[k] = advance_timer(open_ms[k]);
                if (open_ms[k] >= cfg_model.debounce_time) key_act[k] = ACT_RELEASED;
            end else begin
                key_act[k] = ACT_IDLE;
                held_ms[k] = '0;
                open_ms[k] = advance_timer(open_ms[k]);
            end
        end else if (key_act[k] != ACT_RELEASED) begin
            if (key_act[k] == ACT_PRESSED) open_ms[k] = '0;
            held_ms[k] = advance_timer(held_ms[k]);
            if (held_ms[k] >= cfg_model.debounce_time) key_act[k] = ACT_PRESSED;
        end else begin
            key_act[k] = ACT_IDLE;
            held_ms[k] = '0;
            open_ms[k] = 16'd1;
        end
        if (cfg_model.notify_enable[k]) begin
            if (alert_left[k] != 0) begin
                if (alert_left[k] >= cfg_model.tick_period) begin
                    alert_left[k] = alert_left[k] - cfg_model.tick_period;
                end else begin
                    alert_left[k] = '0;
                end
                timed = (alert_left[k] == 0);
            end
            changed = (key_act[k] != last_act[k]);
            if (timed || changed) begin
                if (key_act[k] == ACT_RELEASED) alert_left[k] = cfg_model.click_gap;
                if (last_act[k] != ACT_PRESSED && key_act[k] == ACT_PRESSED) begin
                    alert_left[k] = '0;
                    if (burst_clicks[k] < CLICK_MAX) burst_clicks[k]++;
                end
                if (key_act[k] == ACT_IDLE && open_ms[k] >= cfg_model.click_gap) begin
                    done = burst_clicks[k];
                    burst_clicks[k] = '0;
                end
            end
        end
        last_act[k] = key_act[k];
        r.key_number     = tick.key_index;
        r.action         = key_act[k];
        r.notify_changed = changed;
        r.notify_timed   = timed;
        r.press_time     = held_ms[k];
        r.release_time   = open_ms[k];
        r.click_count    = done;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            mismatch_total++;
        end
    endtask

    always @(negedge i_clk) begin
        if (!in_valid || in_taken) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
                in_valid <= 1'b1;
                in_item  <= pending_ticks.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && !o_in_stall;
            if (in_valid && !o_in_stall) expected_reports.push_back(predict_scan(in_item));
            if (o_out_valid && !out_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("result for key %0d with no transaction pending",
                           o_out_data.key_number);
                    mismatch_total++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("key_number", 16'(want.key_number),
                                16'(o_out_data.key_number));
                    check_field("action", 16'(want.action), 16'(o_out_data.action));
                    check_field("notify_changed", 16'(want.notify_changed),
                                16'(o_out_data.notify_changed));
                    check_field("notify_timed", 16'(want.notify_timed),
                                16'(o_out_data.notify_timed));
                    check_field("press_time", want.press_time, o_out_data.press_time);
                    check_field("release_time", want.release_time, o_out_data.release_time);
                    check_field("click_count", 16'(want.click_count),
                                16'(o_out_data.click_count));
                    if (int'(want.click_count) > top_burst) top_burst = int'(want.click_count);
                    checked_total++;
                end
            end
        end
    end

    task automatic push_run(input int key, input logic level, input int count);
        t_in_item t;
        for (int i = 0; i < count; i++) begin
            t.key_index = 3'(key);
            t.key_level = level;
            pending_ticks.push_back(t);
            queued_total++;
        end
    endtask

    task automatic push_bursts(input int n_ticks);
        int start;
        int k;
        start = queued_total;
        while (queued_total - start < n_ticks) begin
            k = $urandom_range(KEY_COUNT - 1);
            if ($urandom_range(99) < 15) begin
                push_run(k, 1'($urandom_range(1)), 1);
            end else begin
                push_run(k, 1'b1, $urandom_range(1, 8));
                push_run(k, 1'b0, $urandom_range(1, 12));
            end
        end
    endtask

    task automatic wait_drained();
        while (checked_total != queued_total) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TICK_PERIOD:   cfg_model.tick_period = val;
            CFG_DEBOUNCE_TIME: cfg_model.debounce_time = val;
            CFG_NOTIFY_ENABLE: cfg_model.notify_enable = val[7:0];
            CFG_CLICK_GAP:     cfg_model.click_gap = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input t_cfg c);
        wait_drained();
        write_reg(CFG_TICK_PERIOD, c.tick_period);
        write_reg(CFG_DEBOUNCE_TIME, c.debounce_time);
        write_reg(CFG_NOTIFY_ENABLE, {8'd0, c.notify_enable});
        write_reg(CFG_CLICK_GAP, c.click_gap);
        settings_total++;
    endtask

    initial begin : stimulus
        t_cfg plan[6];
        int   storm_key;
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_TICK_PERIOD;
        cfg_data  = '0;
        cfg_model = '{RST_TICK_PERIOD, RST_DEBOUNCE_TIME, RST_NOTIFY_ENABLE, RST_CLICK_GAP};
        for (int k = 0; k < KEY_COUNT; k++) begin
            key_act[k] = ACT_IDLE;
            last_act[k] = ACT_IDLE;
            held_ms[k] = '0;
            open_ms[k] = '0;
            alert_left[k] = '0;
            burst_clicks[k] = '0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default settings: all keys disabled, so no notification or click report.
        settings_total = 1;
        push_run(0, 1'b1, 3);
        push_run(0, 1'b0, 3);
        push_run(7, 1'b1, 1);

        // A full click on the top key with notifications, then the gap expiring.
        apply_setting('{16'd10, 16'd20, 8'hFF, 16'd30});
        push_run(7, 1'b1, 2);
        push_run(7, 1'b0, 2);
        push_run(7, 1'b1, 1);
        push_run(7, 1'b0, 4);
        push_run(5, 1'b1, 1);
        push_run(5, 1'b0, 1);
        push_run(0, 1'b1, 2);

        plan[0] = '{16'd10, 16'd20, 8'hFF, 16'd30};
        plan[1] = '{16'd1, 16'd0, 8'hFF, 16'd0};
        plan[2] = '{16'd65535, 16'd0, 8'hA5, 16'd65535};
        plan[3] = '{16'd30000, 16'd65535, 8'h5A, 16'd65535};
        plan[4] = '{16'd5000, 16'd15000, 8'hFF, 16'd20000};
        plan[5] = '{16'($urandom_range(1, 40)), 16'($urandom_range(0, 80)),
                    8'($urandom_range(255)), 16'($urandom_range(0, 300))};
        for (int p = 0; p < 6; p++) begin
            apply_setting(plan[p]);
            idle_pct = (p == 1) ? 0 : 33;
            if (p == 0) hold_req = 1'b1;
            push_bursts(PHASE_TICKS);
        end

        // Long click burst on one key to drive the click counter into saturation,
        // then a long release so the notify countdown ends the burst.
        apply_setting('{16'd1000, 16'd0, 8'hFF, 16'd60001});
        idle_pct = 33;
        storm_key = $urandom_range(KEY_COUNT - 1);
        for (int i = 0; i < BURST_CLICKS; i++) begin
            push_run(storm_key, 1'b1, 1);
            push_run(storm_key, 1'b0, 1);
            push_run(storm_key, 1'b1, 1);
        end
        push_run(storm_key, 1'b0, 70);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            $error("%0d expected results never arrived", expected_reports.size());
            mismatch_total++;
        end
        $display("Checked %0d scan ticks over %0d register settings.",
                 checked_total, settings_total);
        $display("Largest click burst reported: %0d clicks.", top_burst);
        if (mismatch_total == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/kad_pkg.sv
src/kad_cfg_regs.sv
src/kad_key_state.sv
src/key_action_debouncer_unit.sv
dv/key_action_debouncer_unit_tb.sv
